FILE: src/trpr_pkg.sv
// Shared types and constants for the touch report parser.
// No dependencies; imported by trpr_point and touch_report_parser_rotate.
package trpr_pkg;

  localparam int unsigned MAX_POINTS = 4;
  localparam int unsigned CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int unsigned IDX_W      = 2;

  localparam logic [15:0] PANEL_WIDTH  = 16'd960;
  localparam logic [15:0] PANEL_HEIGHT = 16'd540;

  localparam logic [7:0] ABORT_CODE = 8'hAB;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

  // header byte positions
  localparam logic [2:0] POS_COUNT = 3'd5;
  localparam logic [2:0] POS_SKIP  = 3'd6;
  localparam logic [2:0] POS_REC   = 3'd7;

  localparam logic [2:0] OFF_LAST = 3'd4;

  typedef enum logic [1:0] {
    ROT_LANDSCAPE     = 2'd0,
    ROT_PORTRAIT      = 2'd1,
    ROT_INV_LANDSCAPE = 2'd2,
    ROT_INV_PORTRAIT  = 2'd3
  } rot_mode_t;

  typedef struct packed {
    logic [3:0]  touch_id;
    logic [3:0]  touch_state;
    logic [15:0] screen_x;
    logic [15:0] screen_y;
  } point_t;

endpackage

FILE: src/trpr_point.sv
// Decodes one 4-byte touch record into id, state and rotated coordinates.
// Depends on trpr_pkg.
module trpr_point (
  input  logic [31:0]          rec,
  input  trpr_pkg::rot_mode_t  rot,
  output trpr_pkg::point_t     pt
);
  import trpr_pkg::*;

  logic [15:0] raw_x;
  logic [15:0] raw_y;

  assign raw_y = {4'd0, rec[15:8], rec[31:28]};
  assign raw_x = {4'd0, rec[23:16], rec[27:24]};

  always_comb begin
    pt.touch_id    = rec[7:4];
    pt.touch_state = rec[3:0];
    case (rot)
      ROT_LANDSCAPE: begin
        pt.screen_x = raw_x;
        pt.screen_y = PANEL_HEIGHT - raw_y;
      end
      ROT_PORTRAIT: begin
        pt.screen_x = PANEL_HEIGHT - raw_y;
        pt.screen_y = PANEL_WIDTH - raw_x;
      end
      ROT_INV_LANDSCAPE: begin
        pt.screen_x = PANEL_WIDTH - raw_x;
        pt.screen_y = raw_y;
      end
      default: begin
        pt.screen_x = raw_y;
        pt.screen_y = raw_x;
      end
    endcase
  end

endmodule

FILE: src/touch_report_parser_rotate.sv
// Touch report parser with screen rotation: top level.
// Depends on trpr_pkg and trpr_point.
//
// Input stream: one report byte per beat, in_tuser high on the byte at
// register 0. Output stream: one beat per touch point, or one empty beat
// (out_tuser low) for an aborted or zero-count report; out_tlast marks the
// final beat of a report. Record 0 comes out with the count byte, later
// records with the last byte of their 5-byte group.
// Latency: a result is valid on out_* the cycle after the byte that causes
// it. Throughput: one byte per cycle unless a result stalls; the parser
// state updates in the accepting cycle, the output register only on emits.
// The output register lets a new byte in whenever the held result is taken
// in the same cycle; while the receiver stalls a held result, in_tready is
// low. Bytes without a start mark while idle are dropped.
// Reset: parser idle until a start byte, output empty, rotation landscape.
// cfg_wr_en writes the rotation mode; write only while the block is idle.
module touch_report_parser_rotate (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] report_byte
  input  logic        in_tuser,   // [0] start_of_report
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [1:0] point_index, [5:2] touch_id, [9:6] touch_state,
                                  // [25:10] screen_x, [41:26] screen_y, [47:42] zero
  output logic        out_tuser,  // [0] point_present
  output logic        out_tlast   // last_of_report
);
  import trpr_pkg::*;

  rot_mode_t        rot_r;
  logic             finished_r, finished_nxt;
  logic [2:0]       pos_r, pos_nxt;
  logic [2:0]       off_r, off_nxt;
  logic [2:0]       k_r, k_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      first_r, first_nxt;
  logic [31:0]      rec_r, rec_nxt;

  logic             ov_r;
  logic [47:0]      od_r, od_nxt;
  logic             ou_r, ou_nxt;
  logic             ol_r, ol_nxt;

  logic             accept;
  logic             emit;
  logic             use_first;
  logic [2:0]       p;
  logic [3:0]       n_raw;
  logic [CNT_W-1:0] n_cl;
  logic [IDX_W-1:0] idx;
  point_t           pt;

  assign in_tready = !ov_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign p         = in_tuser ? 3'd0 : pos_r;
  assign n_raw     = in_tdata[3:0];
  assign n_cl      = (n_raw > 4'(MAX_POINTS)) ? MAX_CNT : n_raw[CNT_W-1:0];

  trpr_point u_point (
    .rec (use_first ? first_r : rec_r),
    .rot (rot_r),
    .pt  (pt)
  );

  always_comb begin
    finished_nxt = finished_r;
    pos_nxt      = pos_r;
    off_nxt      = off_r;
    k_nxt        = k_r;
    cnt_nxt      = cnt_r;
    first_nxt    = first_r;
    rec_nxt      = rec_r;
    emit         = 1'b0;
    use_first    = 1'b1;
    idx          = '0;
    ou_nxt       = 1'b0;
    ol_nxt       = 1'b1;
    if (accept && (in_tuser || !finished_r)) begin
      finished_nxt = 1'b0;
      if (p == 3'd0 && in_tdata >= ABORT_CODE) begin
        finished_nxt = 1'b1;
        emit         = 1'b1;
      end else if (p < POS_COUNT) begin
        case (p[1:0])
          2'd0:    first_nxt[7:0]   = in_tdata;
          2'd1:    first_nxt[15:8]  = in_tdata;
          2'd2:    first_nxt[23:16] = in_tdata;
          default: first_nxt[31:24] = in_tdata;
        endcase
        if (p == 3'd4) first_nxt = first_r;
        pos_nxt = p + 3'd1;
      end else if (p == POS_COUNT) begin
        cnt_nxt = n_cl;
        pos_nxt = POS_SKIP;
        emit    = 1'b1;
        if (n_cl == '0) begin
          finished_nxt = 1'b1;
        end else begin
          ou_nxt       = 1'b1;
          ol_nxt       = (n_cl == CNT_W'(1));
          finished_nxt = ol_nxt;
        end
      end else if (p == POS_SKIP) begin
        pos_nxt = POS_REC;
        off_nxt = 3'd0;
        k_nxt   = 3'd1;
      end else begin
        if (off_r < OFF_LAST) begin
          case (off_r[1:0])
            2'd0:    rec_nxt[7:0]   = in_tdata;
            2'd1:    rec_nxt[15:8]  = in_tdata;
            2'd2:    rec_nxt[23:16] = in_tdata;
            default: rec_nxt[31:24] = in_tdata;
          endcase
          off_nxt = off_r + 3'd1;
        end else begin
          emit         = 1'b1;
          use_first    = 1'b0;
          idx          = k_r[IDX_W-1:0];
          ou_nxt       = 1'b1;
          ol_nxt       = ({1'b0, k_r} + 4'd1) >= 4'(cnt_r);
          finished_nxt = ol_nxt;
          off_nxt      = 3'd0;
          k_nxt        = k_r + 3'd1;
        end
      end
      if (in_tuser) cnt_nxt = (p == POS_COUNT) ? n_cl : '0;
    end
    if (ou_nxt) begin
      od_nxt = {6'd0, pt.screen_y, pt.screen_x, pt.touch_state, pt.touch_id, idx};
    end else begin
      od_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r      <= ROT_LANDSCAPE;
      finished_r <= 1'b1;
      pos_r      <= '0;
      off_r      <= '0;
      k_r        <= '0;
      cnt_r      <= '0;
      first_r    <= '0;
      rec_r      <= '0;
      ov_r       <= 1'b0;
    end else begin
      if (cfg_wr_en) rot_r <= rot_mode_t'(cfg_wr_data);
      finished_r <= finished_nxt;
      pos_r      <= pos_nxt;
      off_r      <= off_nxt;
      k_r        <= k_nxt;
      cnt_r      <= cnt_nxt;
      first_r    <= first_nxt;
      rec_r      <= rec_nxt;
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      od_r <= od_nxt;
      ou_r <= ou_nxt;
      ol_r <= ol_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
  assign out_tlast  = ol_r;

endmodule
